// ===== rtl/radix_digit_string_converter_top_defines.svh =====
// assertion macros for the radix digit string converter
// used by radix_digit_string_converter_top, no other dependencies
`ifndef RADIX_DIGIT_STRING_CONVERTER_TOP_DEFINES_SVH
`define RADIX_DIGIT_STRING_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RDSC_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RDSC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rdsc_pkg.sv =====
// shared types, constants and helper functions of the radix digit string converter
// no dependencies
package rdsc_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 7;
  localparam int RADIX_W     = 5;
  localparam int STEP_BITS   = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CH_DIGIT0  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] b);
    logic [RADIX_W-1:0] r;
    r = b;
    if (b < RADIX_MIN) r = RADIX_MIN;
    if (b > RADIX_MAX) r = RADIX_MAX;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                      input logic lower);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_DIGIT0 + CHAR_W'(d);
    end else begin
      c = (lower ? CH_LOWER_A : CH_UPPER_A) + CHAR_W'(d) - 7'd10;
    end
    return c;
  endfunction

endpackage

// ===== rtl/rdsc_div.sv =====
// iterative division of the working value by the radix, STEP_BITS quotient bits per cycle
// depends on rdsc_pkg
module rdsc_div import rdsc_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [VALUE_BITS-1:0] operand,
  input  logic [RADIX_W-1:0]    radix,
  output logic [VALUE_BITS-1:0] quotient,
  output div_res_t              res
);

  localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W  = CHUNKS * STEP_BITS;
  localparam int CNT_W  = $clog2(CHUNKS + 1);

  // dividend bits shift out at the top while quotient bits shift in at the bottom
  logic [DIV_W-1:0]     work;
  logic [DIV_W-1:0]     work_next;
  logic [DIGIT_W-1:0]   rem;
  logic [DIGIT_W-1:0]   rem_next;
  logic [CNT_W-1:0]     cnt;
  logic                 running;
  logic                 done;

  always_comb begin
    logic [STEP_BITS-1:0] chunk;
    logic [STEP_BITS-1:0] qbits;
    logic [DIGIT_W-1:0]   r;
    logic [RADIX_W-1:0]   t;
    chunk = work[DIV_W-1 -: STEP_BITS];
    qbits = '0;
    r     = rem;
    for (int i = 0; i < STEP_BITS; i++) begin
      // remainder stays below the radix, so t stays below twice the radix
      t = {r, chunk[STEP_BITS-1-i]};
      if (t >= radix) begin
        t                      = t - radix;
        qbits[STEP_BITS-1-i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next  = r;
    work_next = (work << STEP_BITS) | DIV_W'(qbits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CHUNKS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work <= DIV_W'(operand);
      rem  <= '0;
    end else if (running) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient = work[VALUE_BITS-1:0];
  assign res.done = done;
  assign res.rem  = rem;

endmodule

// ===== rtl/rdsc_store.sv =====
// digit store: one write port, one read port with registered read data
// depends on rdsc_pkg
module rdsc_store import rdsc_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [DIGIT_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [DIGIT_W-1:0] rdata
);

  logic [DIGIT_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/radix_digit_string_converter_top.sv =====
// top level of the radix digit string converter: control sequencer, divider and digit store
// depends on rdsc_pkg, rdsc_div, rdsc_store and radix_digit_string_converter_top_defines.svh
`include "radix_digit_string_converter_top_defines.svh"

// Converts a VALUE_BITS-wide unsigned value to ASCII digits in radix 2..16 (clamped),
// most significant digit first, one digit per strobe beat with last on the final one.
// A value is taken when start is high and busy is low. Each digit costs one pass of the
// shared divider over C = ceil(VALUE_BITS/8) chunks, which retires 8 quotient bits a cycle;
// the digits then stream out of the digit store at one per cycle. busy stays high until the
// last digit has been read from the store, so the next value waits for it. Digits leave on
// strobe with no backpressure: the receiver must take every beat.
module radix_digit_string_converter_top import rdsc_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_W-1:0]    base,
  input  logic                  func,
  output logic                  strobe,
  output logic [CHAR_W-1:0]     digit_char,
  output logic                  last
);

  state_t               state;
  state_t               state_next;
  logic [RADIX_W-1:0]   radix;
  logic                 lower;
  logic [COUNT_W-1:0]   digit_count;
  logic [COUNT_W-1:0]   count_inc;
  logic [ADDR_W-1:0]    ecnt;
  logic                 rd_valid;
  logic                 rd_last;

  logic                 div_load;
  logic [VALUE_BITS-1:0] div_operand;
  logic [VALUE_BITS-1:0] quotient;
  div_res_t             div_res;

  logic                 st_we;
  logic                 st_re;
  logic [DIGIT_W-1:0]   st_rdata;

  logic                 accept;
  logic                 room;
  logic                 final_digit;

  assign accept      = start && !busy;
  assign busy        = (state != ST_IDLE);
  assign room        = (digit_count < COUNT_W'(STORE_DEPTH));
  assign count_inc   = room ? digit_count + 1'b1 : digit_count;
  assign final_digit = div_res.done && (quotient == '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_DIVIDE;
      ST_DIVIDE: if (final_digit) state_next = ST_EMIT;
      ST_EMIT:   if (ecnt == '0) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs toward the divider and the store
  always_comb begin
    div_load    = 1'b0;
    div_operand = value;
    st_we       = 1'b0;
    st_re       = 1'b0;
    case (state)
      ST_IDLE: begin
        div_load = start;
      end
      ST_DIVIDE: begin
        st_we       = div_res.done && room;
        div_load    = div_res.done && (quotient != '0);
        div_operand = quotient;
      end
      ST_EMIT: begin
        st_re = 1'b1;
      end
      default: begin
        div_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      digit_count <= '0;
      rd_valid    <= 1'b0;
      rd_last     <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_EMIT);
      rd_last  <= (state == ST_EMIT) && (ecnt == '0);
      if (accept) begin
        digit_count <= '0;
      end else if (state == ST_DIVIDE && div_res.done) begin
        digit_count <= count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      radix <= clamp_radix(base);
      lower <= func;
    end
    // digits come out from the highest store address down to zero
    if (state == ST_DIVIDE && final_digit) begin
      ecnt <= ADDR_W'(count_inc - 1'b1);
    end else if (state == ST_EMIT) begin
      ecnt <= ecnt - 1'b1;
    end
  end

  rdsc_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .operand  (div_operand),
    .radix    (radix),
    .quotient (quotient),
    .res      (div_res)
  );

  rdsc_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (digit_count[ADDR_W-1:0]),
    .wdata (div_res.rem),
    .re    (st_re),
    .raddr (ecnt),
    .rdata (st_rdata)
  );

  assign strobe     = rd_valid;
  assign last       = rd_last;
  assign digit_char = digit_to_ascii(st_rdata, lower);

  `RDSC_ASSERT_SAME(a_char_legal, clk, rst, strobe,
    (digit_char >= 7'd48 && digit_char <= 7'd57) ||
    (digit_char >= 7'd65 && digit_char <= 7'd70) ||
    (digit_char >= 7'd97 && digit_char <= 7'd102), "digit character out of range")
  `RDSC_ASSERT_NEXT(a_busy_after_accept, clk, rst, start && !busy, busy,
    "busy not raised after accepting a value")
  `RDSC_ASSERT_NEXT(a_last_ends_item, clk, rst, strobe && last, !strobe,
    "digit beat follows the last digit")
  `RDSC_ASSERT_SAME(a_no_beat_while_dividing, clk, rst, state == ST_DIVIDE, !strobe,
    "digit beat during division")

endmodule

// ===== sim/tb_radix_digit_string_converter_top.sv =====
// self-checking testbench of radix_digit_string_converter_top: directed and random values
// depends on rdsc_pkg and the converter rtl; the digit string is predicted inside the bench
`timescale 1ns / 1ps

module tb_radix_digit_string_converter_top import rdsc_pkg::*;;

  localparam int VALUE_BITS   = 64;
  localparam int RANDOM_ITEMS = 340;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int IDLE_PCT     = 32;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } digit_beat_t;

  // predicts the digit beats of each accepted value and checks them in order
  class digit_string_tracker;
    digit_beat_t pending_digits[$];
    int          values_taken;
    int          digits_checked;
    int          mismatches;

    function void note_value(logic [VALUE_BITS-1:0] v, logic [RADIX_W-1:0] b, logic lower);
      logic [DIGIT_W-1:0] rev [64];
      logic [63:0]        radix;
      logic [63:0]        rest;
      logic [DIGIT_W-1:0] d;
      digit_beat_t        beat;
      int                 n;
      radix = (b < 5'd2) ? 64'd2 : (b > 5'd16) ? 64'd16 : 64'(b);
      rest  = 64'(v);
      n     = 0;
      // least significant digit first, emitted in reverse
      do begin
        rev[n] = DIGIT_W'(rest % radix);
        n++;
        rest = rest / radix;
      end while (rest != 0);
      for (int k = n - 1; k >= 0; k--) begin
        d = rev[k];
        if (d < 4'd10) begin
          beat.ch = CH_DIGIT0 + CHAR_W'(d);
        end else begin
          beat.ch = (lower ? CH_LOWER_A : CH_UPPER_A) + CHAR_W'(d - 4'd10);
        end
        beat.fin = (k == 0);
        pending_digits.push_back(beat);
      end
      values_taken++;
    endfunction

    function void check_digit(logic [CHAR_W-1:0] ch, logic fin);
      digit_beat_t want;
      if (pending_digits.size() == 0) begin
        $error("unexpected digit beat: digit_char %0h last %0b", ch, fin);
        mismatches++;
        return;
      end
      want = pending_digits.pop_front();
      digits_checked++;
      if (ch !== want.ch) begin
        $error("digit_char: expected %0h, got %0h", want.ch, ch);
        mismatches++;
      end
      if (fin !== want.fin) begin
        $error("last: expected %0b, got %0b", want.fin, fin);
        mismatches++;
      end
    endfunction

    function int pending_count();
      return pending_digits.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [VALUE_BITS-1:0] value = '0;
  logic [RADIX_W-1:0]    base = '0;
  logic                  func = 1'b0;
  logic                  strobe;
  logic [CHAR_W-1:0]     digit_char;
  logic                  last;

  digit_string_tracker tracker = new();
  int                  cycle_count = 0;
  logic [31:0]         bases_seen = '0;
  bit                  idle_on = 1'b1;

  radix_digit_string_converter_top #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .base      (base),
    .func      (func),
    .strobe    (strobe),
    .digit_char(digit_char),
    .last      (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // a digit beat on the same edge as a new value still belongs to the previous value
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) tracker.check_digit(digit_char, last);
      if (start && !busy) begin
        tracker.note_value(value, base, func);
        bases_seen[base] = 1'b1;
      end
    end
  end

  // maybe idle for a while once the block is free, then present one value until taken
  task automatic send_value(logic [VALUE_BITS-1:0] v, logic [RADIX_W-1:0] b, logic lower);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      value <= {$urandom(), $urandom()};
      do @(posedge clk); while (busy);
      repeat (gap - 1) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    base  <= b;
    func  <= lower;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [63:0] v;
    int          sel;
    int          w;
    v   = {$urandom(), $urandom()};
    sel = $urandom_range(99);
    w   = $urandom_range(64, 1);
    if (sel < 40) return v;
    if (sel < 70) return v & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - w));
    if (sel < 82) return 64'($urandom_range(40));
    if (sel < 88) return 64'd1 << (w - 1);
    if (sel < 94) return (64'd1 << (w - 1)) - 64'd1;
    return (sel < 97) ? 64'd0 : 64'hFFFF_FFFF_FFFF_FFFF;
  endfunction

  function automatic logic [RADIX_W-1:0] pick_base();
    if ($urandom_range(99) < 80) return RADIX_W'($urandom_range(16, 2));
    return RADIX_W'($urandom_range(31, 0));
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, both letter cases, radix clamping and zero
    send_value(64'd0, 5'd10, 1'b0);
    send_value(64'd0, 5'd31, 1'b1);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 1'b0);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 1'b0);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 1'b1);
    send_value(64'hFEDC_BA98_7654_3210, 5'd16, 1'b1);
    send_value(64'hFEDC_BA98_7654_3210, 5'd16, 1'b0);
    send_value(64'd255, 5'd0, 1'b0);
    send_value(64'd255, 5'd1, 1'b1);
    send_value(64'd255, 5'd17, 1'b1);
    send_value(64'd255, 5'd31, 1'b0);
    send_value(64'd1, 5'd2, 1'b0);
    send_value(64'd10, 5'd11, 1'b0);
    send_value(64'd10, 5'd11, 1'b1);
    send_value(64'd15, 5'd16, 1'b1);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 5'd3, 1'b0);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 5'd7, 1'b1);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 5'd10, 1'b0);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 5'd13, 1'b1);
    send_value(64'h8000_0000_0000_0000, 5'd2, 1'b0);
    send_value(64'd12, 5'd12, 1'b0);

    // random values, with a back-to-back stretch in the middle
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = !(i >= 140 && i < 200);
      send_value(pick_value(), pick_base(), 1'($urandom_range(1)));
    end
    start <= 1'b0;

    // let the monitor note the last value before waiting on its digits
    @(posedge clk);
    while (tracker.pending_count() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d values converted, %0d digit beats checked, %0d of 32 base codes used",
             tracker.values_taken, tracker.digits_checked, $countones(bases_seen));
    if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
